>>> hw/rtl/vias_pkg.sv
// Shared types, register codes and equalizer tables for the input auto-switch.
`default_nettype none
package vias_pkg;

	// Port selection
	localparam int PORT_W        = 2;
	localparam int MASK_W        = 3;
	localparam int NUM_PORTS_DEF = 3;
	localparam logic [PORT_W-1:0] PORT_NONE = 2'd3;

	// Queue between front and back
	localparam int QUEUE_DEPTH_DEF = 2;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_FOUR_K_THR  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CLK_MARGIN  = 2'd1;
	localparam logic [7:0] FOUR_K_THR_RST = 8'd72;
	localparam logic [7:0] CLK_MARGIN_RST = 8'd2;

	// Device registers and values
	localparam logic [7:0] REG_PORT_SEL  = 8'h0F;
	localparam logic [7:0] REG_OUT_CTRL  = 8'h20;
	localparam logic [7:0] REG_CLK_MEAS  = 8'h05;
	localparam logic [7:0] REG_LDO       = 8'h36;
	localparam logic [7:0] DAT_PORT_OFF  = 8'h03;
	localparam logic [7:0] DAT_MUTE      = 8'h03;
	localparam logic [7:0] DAT_UNMUTE    = 8'h0F;
	localparam logic [7:0] DAT_MEAS_RST  = 8'h03;
	localparam logic [7:0] DAT_MEAS_RUN  = 8'h07;
	localparam logic [7:0] DAT_LDO_OFF   = 8'h81;

	// Equalizer table
	localparam int EQ_LEN   = 10;
	localparam int EQ_IDX_W = $clog2(EQ_LEN);

	// Clock action of one poll
	localparam logic [1:0] CLK_ACT_NONE = 2'd0;
	localparam logic [1:0] CLK_ACT_MUTE = 2'd1;
	localparam logic [1:0] CLK_ACT_EQ   = 2'd2;

	// Work plan of one poll, handed from front to back
	typedef struct packed {
		logic              search_fail;
		logic              do_switch;
		logic [PORT_W-1:0] port;
		logic [1:0]        clk_act;
		logic              four_k;
	} plan_t;

	function automatic logic [7:0] eq_addr_f(input logic [EQ_IDX_W-1:0] idx);
		logic [7:0] a;
		case (idx)
			4'd0: a = 8'h11;
			4'd1: a = 8'h12;
			4'd2: a = 8'h13;
			4'd3: a = 8'h14;
			4'd4: a = 8'h18;
			4'd5: a = 8'h19;
			4'd6: a = 8'h1E;
			4'd7: a = 8'h21;
			4'd8: a = 8'h22;
			4'd9: a = 8'h25;
			default: a = 8'h00;
		endcase
		return a;
	endfunction

	function automatic logic [7:0] eq_data_f(input logic [EQ_IDX_W-1:0] idx,
			input logic four_k);
		logic [7:0] d;
		if (four_k) begin
			case (idx)
				4'd0: d = 8'h2F;
				4'd1: d = 8'h00;
				4'd2: d = 8'h00;
				4'd3: d = 8'h00;
				4'd4: d = 8'h00;
				4'd5: d = 8'h77;
				4'd6: d = 8'h0B;
				4'd7: d = 8'h7D;
				4'd8: d = 8'h70;
				4'd9: d = 8'h30;
				default: d = 8'h00;
			endcase
		end else begin
			case (idx)
				4'd0: d = 8'h2E;
				4'd1: d = 8'h02;
				4'd2: d = 8'h73;
				4'd3: d = 8'h33;
				4'd4: d = 8'h00;
				4'd5: d = 8'h00;
				4'd6: d = 8'h0B;
				4'd7: d = 8'h73;
				4'd8: d = 8'h00;
				4'd9: d = 8'h22;
				default: d = 8'h00;
			endcase
		end
		return d;
	endfunction

endpackage
`default_nettype wire

>>> hw/rtl/vias_front.sv
// Front end: accepts polls, tracks power and clock state, and plans the writes.
`default_nettype none
module vias_front import vias_pkg::*; #(
	parameter int NUM_PORTS = NUM_PORTS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic                  hold_power_logic,
	input  wire logic [MASK_W-1:0]     rx_5v,
	input  wire logic [7:0]            freq_before,
	input  wire logic [7:0]            freq_after,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	output logic                       plan_push,
	output plan_t                      plan,
	input  wire logic                  plan_room
);

	localparam logic [PORT_W-1:0] NP = PORT_W'(NUM_PORTS);

	logic [7:0]        four_k_thr_q;
	logic [7:0]        clk_margin_q;
	logic [MASK_W-1:0] power_mask_q;
	logic [PORT_W-1:0] selected_q;
	logic [PORT_W-1:0] applied_q;
	logic              first_loss_q;
	logic [7:0]        last_clock_q;
	logic              four_k_q;

	logic [MASK_W-1:0] risen, lost;
	logic              lost_app;
	logic [PORT_W:0]   srch;
	logic              srch_run, srch_fail;
	logic [PORT_W-1:0] sel_n, app_n;
	logic              first_loss_n;
	logic              do_switch;
	logic [7:0]        clk_v, diff;
	logic              clk_upd;
	logic              four_k_n;
	logic [1:0]        clk_act;
	logic              accept;

	// Round-robin: step from start, stop at the first powered port
	function automatic logic [PORT_W:0] search_f(input logic [PORT_W-1:0] start,
			input logic [MASK_W-1:0] mask);
		logic [PORT_W-1:0] s;
		logic              found;
		s = start;
		found = 1'b0;
		for (int i = 0; i < NUM_PORTS; i++) begin
			if (!found) begin
				if (s >= NP - 1'b1)
					s = '0;
				else
					s = s + 1'b1;
				if (mask[s])
					found = 1'b1;
			end
		end
		return {found, s};
	endfunction

	assign in_ready = plan_room;
	assign accept   = in_valid && plan_room;

	// Power step
	always_comb begin
		risen        = rx_5v & ~power_mask_q;
		lost         = power_mask_q & ~rx_5v;
		lost_app     = (applied_q != PORT_NONE) ? lost[applied_q] : 1'b0;
		sel_n        = selected_q;
		app_n        = applied_q;
		first_loss_n = first_loss_q;
		srch_run     = 1'b0;
		srch         = search_f(applied_q, rx_5v);
		if (!hold_power_logic && rx_5v != power_mask_q) begin
			if (risen != '0) begin
				app_n = PORT_NONE;
				for (int i = NUM_PORTS - 1; i >= 0; i--) begin
					if (risen[i])
						sel_n = PORT_W'(i);
				end
			end else if (!first_loss_q && rx_5v != '0) begin
				if (lost_app || rx_5v[2]) begin
					app_n        = PORT_NONE;
					srch         = search_f(PORT_NONE, rx_5v);
					srch_run     = 1'b1;
					first_loss_n = 1'b1;
				end
			end else if (lost_app) begin
				srch_run = 1'b1;
			end
		end
		srch_fail = srch_run && !srch[PORT_W];
		if (srch_run)
			sel_n = srch[PORT_W-1:0];
		// Switch step
		do_switch = (sel_n != app_n) && (sel_n < NP);
		if (do_switch)
			app_n = sel_n;
	end

	// Clock step
	always_comb begin
		clk_v    = (freq_before == freq_after) ? 8'd0 : freq_before;
		diff     = (clk_v >= last_clock_q) ? clk_v - last_clock_q : last_clock_q - clk_v;
		clk_upd  = diff >= clk_margin_q;
		four_k_n = four_k_q;
		clk_act  = CLK_ACT_NONE;
		if (clk_upd) begin
			if (clk_v == 8'd0) begin
				clk_act = CLK_ACT_MUTE;
			end else begin
				clk_act  = CLK_ACT_EQ;
				four_k_n = clk_v > four_k_thr_q;
			end
		end
	end

	assign plan_push        = accept;
	assign plan.search_fail = srch_fail;
	assign plan.do_switch   = do_switch;
	assign plan.port        = sel_n;
	assign plan.clk_act     = clk_act;
	assign plan.four_k      = four_k_n;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			four_k_thr_q <= FOUR_K_THR_RST;
			clk_margin_q <= CLK_MARGIN_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_FOUR_K_THR: four_k_thr_q <= cfg_wdata;
				CFG_CLK_MARGIN: clk_margin_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Commit poll state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			power_mask_q <= '0;
			selected_q   <= '0;
			applied_q    <= '0;
			first_loss_q <= 1'b0;
			last_clock_q <= '0;
			four_k_q     <= 1'b0;
		end else if (accept) begin
			if (!hold_power_logic)
				power_mask_q <= rx_5v;
			selected_q   <= sel_n;
			applied_q    <= app_n;
			first_loss_q <= first_loss_n;
			four_k_q     <= four_k_n;
			if (clk_upd)
				last_clock_q <= clk_v;
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/vias_fifo.sv
// Short plan queue between the front end and the write sequencer.
`default_nettype none
module vias_fifo import vias_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  wr_en,
	input  wire plan_t wr_data,
	output logic       wr_room,
	input  wire logic  rd_en,
	output plan_t      rd_data,
	output logic       rd_valid
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	plan_t            slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr, do_rd;

	assign wr_room  = count_q != FULL_CNT;
	assign rd_valid = count_q != '0;
	assign rd_data  = slot_q[rd_ptr_q];
	assign do_wr    = wr_en && wr_room;
	assign do_rd    = rd_en && rd_valid;

	// Store plan
	always_ff @(posedge clk) begin
		if (do_wr)
			slot_q[wr_ptr_q] <= wr_data;
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			if (do_rd)
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			if (do_wr && !do_rd)
				count_q <= count_q + 1'b1;
			else if (do_rd && !do_wr)
				count_q <= count_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/vias_back.sv
// Write sequencer: plan to device reg writes, one per cycle unless stalled.
`default_nettype none
module vias_back import vias_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire plan_t      plan_in,
	input  wire logic       plan_valid,
	output logic            plan_pop,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      reg_addr,
	output logic [7:0]      reg_data,
	output logic            last
);

	localparam logic [3:0] ST_SRCH  = 4'd0;
	localparam logic [3:0] ST_SW0   = 4'd1;
	localparam logic [3:0] ST_SW1   = 4'd2;
	localparam logic [3:0] ST_SW2   = 4'd3;
	localparam logic [3:0] ST_CK0   = 4'd4;
	localparam logic [3:0] ST_CK1   = 4'd5;
	localparam logic [3:0] ST_MUTE  = 4'd6;
	localparam logic [3:0] ST_EQ    = 4'd7;
	localparam logic [3:0] ST_EQEND = 4'd8;
	localparam logic [3:0] ST_LDO   = 4'd9;

	localparam logic [EQ_IDX_W-1:0] EQ_LAST = EQ_IDX_W'(EQ_LEN - 1);

	plan_t               plan_q;
	logic                busy_q;
	logic [3:0]          step_q;
	logic [EQ_IDX_W-1:0] eq_idx_q;
	logic                out_valid_q;
	logic [7:0]          reg_addr_q, reg_data_q;
	logic                last_q;

	logic                adv;
	logic [3:0]          first_step, next_step;
	logic [7:0]          cur_addr, cur_data;
	logic                cur_last;

	assign adv      = busy_q && (!out_valid_q || out_ready);
	assign plan_pop = !busy_q && plan_valid;

	// Pick the opening write of a new plan
	always_comb begin
		if (plan_in.search_fail)
			first_step = ST_SRCH;
		else if (plan_in.do_switch)
			first_step = ST_SW0;
		else
			first_step = ST_CK0;
	end

	// Decode current write and the step after it
	always_comb begin
		cur_addr  = REG_LDO;
		cur_data  = DAT_LDO_OFF;
		cur_last  = 1'b0;
		next_step = ST_LDO;
		unique case (step_q)
			ST_SRCH: begin
				cur_addr  = REG_PORT_SEL;
				cur_data  = DAT_PORT_OFF;
				next_step = plan_q.do_switch ? ST_SW0 : ST_CK0;
			end
			ST_SW0: begin
				cur_addr  = REG_OUT_CTRL;
				cur_data  = DAT_MUTE;
				next_step = ST_SW1;
			end
			ST_SW1: begin
				cur_addr  = REG_PORT_SEL;
				cur_data  = DAT_PORT_OFF;
				next_step = ST_SW2;
			end
			ST_SW2: begin
				cur_addr  = REG_PORT_SEL;
				cur_data  = {{(8 - PORT_W){1'b0}}, plan_q.port};
				next_step = ST_CK0;
			end
			ST_CK0: begin
				cur_addr  = REG_CLK_MEAS;
				cur_data  = DAT_MEAS_RST;
				next_step = ST_CK1;
			end
			ST_CK1: begin
				cur_addr = REG_CLK_MEAS;
				cur_data = DAT_MEAS_RUN;
				case (plan_q.clk_act)
					CLK_ACT_MUTE: next_step = ST_MUTE;
					CLK_ACT_EQ:   next_step = ST_EQ;
					default:      next_step = ST_LDO;
				endcase
			end
			ST_MUTE: begin
				cur_addr  = REG_OUT_CTRL;
				cur_data  = DAT_MUTE;
				next_step = ST_LDO;
			end
			ST_EQ: begin
				cur_addr  = eq_addr_f(eq_idx_q);
				cur_data  = eq_data_f(eq_idx_q, plan_q.four_k);
				next_step = (eq_idx_q == EQ_LAST) ? ST_EQEND : ST_EQ;
			end
			ST_EQEND: begin
				cur_addr  = REG_OUT_CTRL;
				cur_data  = DAT_UNMUTE;
				next_step = ST_LDO;
			end
			ST_LDO: begin
				cur_last  = 1'b1;
				next_step = ST_LDO;
			end
			default: begin
				cur_last  = 1'b1;
				next_step = ST_LDO;
			end
		endcase
	end

	// Load plan
	always_ff @(posedge clk) begin
		if (plan_pop)
			plan_q <= plan_in;
	end

	// Step through the writes of the plan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			step_q   <= ST_LDO;
			eq_idx_q <= '0;
		end else if (plan_pop) begin
			busy_q   <= 1'b1;
			step_q   <= first_step;
			eq_idx_q <= '0;
		end else if (adv) begin
			step_q <= next_step;
			if (step_q == ST_EQ)
				eq_idx_q <= eq_idx_q + 1'b1;
			if (step_q == ST_LDO)
				busy_q <= 1'b0;
		end
	end

	// Hold the write until the request is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			reg_addr_q <= cur_addr;
			reg_data_q <= cur_data;
			last_q     <= cur_last;
		end
	end

	assign out_valid = out_valid_q;
	assign reg_addr  = reg_addr_q;
	assign reg_data  = reg_data_q;
	assign last      = last_q;

endmodule
`default_nettype wire

>>> hw/rtl/video_input_auto_switch.sv
// Video input auto-switch: each poll request updates port power and clock state and
// produces a burst of device register writes, the final one flagged by last. The front
// end takes one poll per cycle while its plan queue (two entries by default) has room;
// the write sequencer issues one write per cycle while out_ready takes them, 3 to 18
// writes per poll, and sets the pace of a steady stream of polls. Configuration writes
// take effect at once; the user must make them while idle, not enforced by the block.
`default_nettype none
module video_input_auto_switch import vias_pkg::*; #(
	parameter int NUM_PORTS   = NUM_PORTS_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic                  hold_power_logic,
	input  wire logic [MASK_W-1:0]     rx_5v,
	input  wire logic [7:0]            freq_before,
	input  wire logic [7:0]            freq_after,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [7:0]                 reg_addr,
	output logic [7:0]                 reg_data,
	output logic                       last,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

	plan_t plan_wr, plan_rd;
	logic  plan_push, plan_room, plan_pop, plan_valid;

	vias_front #(
		.NUM_PORTS(NUM_PORTS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.hold_power_logic(hold_power_logic),
		.rx_5v(rx_5v),
		.freq_before(freq_before),
		.freq_after(freq_after),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata),
		.plan_push(plan_push),
		.plan(plan_wr),
		.plan_room(plan_room)
	);

	vias_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(plan_push),
		.wr_data(plan_wr),
		.wr_room(plan_room),
		.rd_en(plan_pop),
		.rd_data(plan_rd),
		.rd_valid(plan_valid)
	);

	vias_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.plan_in(plan_rd),
		.plan_valid(plan_valid),
		.plan_pop(plan_pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.reg_addr(reg_addr),
		.reg_data(reg_data),
		.last(last)
	);

	// The final write of every poll is the LDO-off write
	a_last_is_ldo: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> reg_addr == REG_LDO && reg_data == DAT_LDO_OFF)
		else $error("last flag on a write other than LDO-off");

	// Writes of one poll come without gaps once the previous one is taken
	a_burst_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> out_valid)
		else $error("gap inside a poll write burst");

	// LDO-off is never left out: the LDO register is written only as the last write
	a_ldo_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && reg_addr == REG_LDO |-> last)
		else $error("LDO write without last flag");

endmodule
`default_nettype wire
